// ===== rtl/core/rti_pkg.sv =====
// Shared types and widths for the ray / triangle intersection block.
// Used by every module under rtl/core; depends on nothing.

package rti_pkg;

   localparam int COORD_W     = 16;               // Q8.8 coordinate
   localparam int DIFF_W      = COORD_W + 1;      // difference of two coordinates
   localparam int PROD1_W     = 2 * DIFF_W;       // first product level
   localparam int PQ_W        = PROD1_W + 1;      // 2x2 minors
   localparam int PROD2_W     = DIFF_W + PQ_W;    // second product level
   localparam int SUM_W       = PROD2_W + 2;      // 3x3 determinants
   localparam int REM_W       = SUM_W + 1;        // divider partial remainder
   localparam int DIST_W      = 32;               // Q16.16 distance
   localparam int FRAC_BITS   = 16;               // distance fraction bits
   localparam int QUO_W       = DIST_W;           // quotient bits, one per divider stage
   localparam int INT_SHIFT   = QUO_W - FRAC_BITS;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int NUM_VERTS   = 3;
   localparam int VSEL_W      = 2;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_RAY  = 1'b1;

   localparam logic [VSEL_W-1:0] VSEL_A = 2'd0;
   localparam logic [VSEL_W-1:0] VSEL_B = 2'd1;
   localparam logic [VSEL_W-1:0] VSEL_C = 2'd2;

   localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
   localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vec_type;

   // One ray after the front end: edge and origin differences, direction, best distance.
   typedef struct packed {
      logic signed [DIFF_W-1:0]  da;
      logic signed [DIFF_W-1:0]  db;
      logic signed [DIFF_W-1:0]  dc;
      logic signed [DIFF_W-1:0]  dd;
      logic signed [DIFF_W-1:0]  de;
      logic signed [DIFF_W-1:0]  df;
      logic signed [COORD_W-1:0] gx;
      logic signed [COORD_W-1:0] hy;
      logic signed [COORD_W-1:0] iz;
      logic signed [DIFF_W-1:0]  jx;
      logic signed [DIFF_W-1:0]  ky;
      logic signed [DIFF_W-1:0]  lz;
      logic signed [DIST_W-1:0]  best;
   } ray_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } queue_stat_type;

   // Normalized determinant terms handed to the divider.
   typedef struct packed {
      logic [SUM_W-1:0]         mag;
      logic [SUM_W-1:0]         den;
      logic                     neg;
      logic                     sat;
      logic                     hit;
      logic                     degen;
      logic signed [DIST_W-1:0] best;
   } div_in_type;

endpackage

// ===== rtl/core/rti_queue.sv =====
// Short queue of classified ray beats between the front and back ends.
// Depends on rti_pkg.

module rti_queue
   import rti_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  ray_type        push_data,
   input  logic           pop,
   output ray_type        pop_data,
   output queue_stat_type stat
);

   ray_type           mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data    = mem[rd_ptr_ff];
   assign stat.count  = count_ff;
   assign stat.full   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty  = (count_ff == '0);

endmodule

// ===== rtl/core/rti_front.sv =====
// Front end: accepts request beats, writes vertex loads into the triangle store
// and turns ray beats into difference vectors for the queue. Depends on rti_pkg.

module rti_front
   import rti_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [127:0]            req_tdata,
   input  logic [2:0]              req_tuser,
   input  queue_stat_type          q_stat,
   output logic                    push,
   output ray_type                 push_data
);

   vec_type           vert_ff [NUM_VERTS];
   vec_type           pos;
   vec_type           dir;
   logic signed [DIST_W-1:0] best;
   logic              kind;
   logic [VSEL_W-1:0] vsel;
   logic              accept;

   assign kind = req_tuser[0];
   assign vsel = req_tuser[2:1];
   assign pos  = '{x: req_tdata[15:0],  y: req_tdata[31:16], z: req_tdata[47:32]};
   assign dir  = '{x: req_tdata[63:48], y: req_tdata[79:64], z: req_tdata[95:80]};
   assign best = req_tdata[127:96];

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && (kind == KIND_RAY);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < NUM_VERTS; v++) begin
            vert_ff[v] <= '0;
         end
      end else if (accept && (kind == KIND_LOAD)) begin
         unique case (vsel)
            VSEL_A:  vert_ff[0] <= pos;
            VSEL_B:  vert_ff[1] <= pos;
            VSEL_C:  vert_ff[2] <= pos;
            default: ;
         endcase
      end
   end

   always_comb begin
      push_data.da   = DIFF_W'(vert_ff[0].x) - DIFF_W'(vert_ff[1].x);
      push_data.db   = DIFF_W'(vert_ff[0].y) - DIFF_W'(vert_ff[1].y);
      push_data.dc   = DIFF_W'(vert_ff[0].z) - DIFF_W'(vert_ff[1].z);
      push_data.dd   = DIFF_W'(vert_ff[0].x) - DIFF_W'(vert_ff[2].x);
      push_data.de   = DIFF_W'(vert_ff[0].y) - DIFF_W'(vert_ff[2].y);
      push_data.df   = DIFF_W'(vert_ff[0].z) - DIFF_W'(vert_ff[2].z);
      push_data.gx   = dir.x;
      push_data.hy   = dir.y;
      push_data.iz   = dir.z;
      push_data.jx   = DIFF_W'(vert_ff[0].x) - DIFF_W'(pos.x);
      push_data.ky   = DIFF_W'(vert_ff[0].y) - DIFF_W'(pos.y);
      push_data.lz   = DIFF_W'(vert_ff[0].z) - DIFF_W'(pos.z);
      push_data.best = best;
   end

endmodule

// ===== rtl/core/rti_back.sv =====
// Back end arithmetic: six pipeline stages forming the Cramer determinants,
// normalizing their sign and evaluating the hit test. Depends on rti_pkg.

module rti_back
   import rti_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       in_valid,
   input  ray_type    in_ray,
   output logic       out_valid,
   output div_in_type out_data
);

   logic [5:0] vld_ff;

   // Stage 1: products of the 2x2 minors.
   logic signed [PROD1_W-1:0] m1_ff [12];
   ray_type                   r1_ff;
   // Stage 2: minors.
   logic signed [PQ_W-1:0]    pq_ff [6];
   ray_type                   r2_ff;
   // Stage 3: products of the 3x3 expansion.
   logic signed [PROD2_W-1:0] m2_ff [12];
   logic signed [DIST_W-1:0]  b3_ff;
   // Stage 4: determinant and numerators.
   logic signed [SUM_W-1:0]   det_ff, nb_ff, ng_ff, nt_ff;
   logic signed [DIST_W-1:0]  b4_ff;
   // Stage 5: sign normalized.
   logic [SUM_W-1:0]          den_ff;
   logic signed [SUM_W-1:0]   nb5_ff, ng5_ff, nt5_ff;
   logic                      degen5_ff;
   logic signed [DIST_W-1:0]  b5_ff;
   div_in_type                out_ff;

   logic signed [PQ_W-1:0]    pq_in [6];
   logic                      det_neg;
   logic signed [SUM_W:0]     bg_sum;
   logic signed [SUM_W-1:0]   nt_abs;
   logic                      hit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_comb begin
      pq_in[0] = PQ_W'(m1_ff[0])  - PQ_W'(m1_ff[1]);
      pq_in[1] = PQ_W'(m1_ff[2])  - PQ_W'(m1_ff[3]);
      pq_in[2] = PQ_W'(m1_ff[4])  - PQ_W'(m1_ff[5]);
      pq_in[3] = PQ_W'(m1_ff[6])  - PQ_W'(m1_ff[7]);
      pq_in[4] = PQ_W'(m1_ff[8])  - PQ_W'(m1_ff[9]);
      pq_in[5] = PQ_W'(m1_ff[10]) - PQ_W'(m1_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff[0]  <= in_ray.de * in_ray.iz;
         m1_ff[1]  <= in_ray.hy * in_ray.df;
         m1_ff[2]  <= in_ray.gx * in_ray.df;
         m1_ff[3]  <= in_ray.dd * in_ray.iz;
         m1_ff[4]  <= in_ray.dd * in_ray.hy;
         m1_ff[5]  <= in_ray.de * in_ray.gx;
         m1_ff[6]  <= in_ray.da * in_ray.ky;
         m1_ff[7]  <= in_ray.jx * in_ray.db;
         m1_ff[8]  <= in_ray.jx * in_ray.dc;
         m1_ff[9]  <= in_ray.da * in_ray.lz;
         m1_ff[10] <= in_ray.db * in_ray.lz;
         m1_ff[11] <= in_ray.ky * in_ray.dc;
         r1_ff     <= in_ray;

         for (int i = 0; i < 6; i++) begin
            pq_ff[i] <= pq_in[i];
         end
         r2_ff <= r1_ff;

         // Minors 0..2 are p1..p3, 3..5 are q1..q3.
         m2_ff[0]  <= r2_ff.da * pq_ff[0];
         m2_ff[1]  <= r2_ff.db * pq_ff[1];
         m2_ff[2]  <= r2_ff.dc * pq_ff[2];
         m2_ff[3]  <= r2_ff.jx * pq_ff[0];
         m2_ff[4]  <= r2_ff.ky * pq_ff[1];
         m2_ff[5]  <= r2_ff.lz * pq_ff[2];
         m2_ff[6]  <= r2_ff.iz * pq_ff[3];
         m2_ff[7]  <= r2_ff.hy * pq_ff[4];
         m2_ff[8]  <= r2_ff.gx * pq_ff[5];
         m2_ff[9]  <= r2_ff.df * pq_ff[3];
         m2_ff[10] <= r2_ff.de * pq_ff[4];
         m2_ff[11] <= r2_ff.dd * pq_ff[5];
         b3_ff     <= r2_ff.best;

         det_ff <= SUM_W'(m2_ff[0]) + SUM_W'(m2_ff[1]) + SUM_W'(m2_ff[2]);
         nb_ff  <= SUM_W'(m2_ff[3]) + SUM_W'(m2_ff[4]) + SUM_W'(m2_ff[5]);
         ng_ff  <= SUM_W'(m2_ff[6]) + SUM_W'(m2_ff[7]) + SUM_W'(m2_ff[8]);
         nt_ff  <= -(SUM_W'(m2_ff[9]) + SUM_W'(m2_ff[10]) + SUM_W'(m2_ff[11]));
         b4_ff  <= b3_ff;

         den_ff    <= det_neg ? unsigned'(-det_ff) : unsigned'(det_ff);
         nb5_ff    <= det_neg ? -nb_ff : nb_ff;
         ng5_ff    <= det_neg ? -ng_ff : ng_ff;
         nt5_ff    <= det_neg ? -nt_ff : nt_ff;
         degen5_ff <= (det_ff == '0);
         b5_ff     <= b4_ff;

         out_ff.mag   <= unsigned'(nt_abs);
         out_ff.den   <= den_ff;
         out_ff.neg   <= nt5_ff[SUM_W-1];
         out_ff.sat   <= (unsigned'(nt_abs) >> INT_SHIFT) >= den_ff;
         out_ff.hit   <= hit_in;
         out_ff.degen <= degen5_ff;
         out_ff.best  <= b5_ff;
      end
   end

   always_comb begin
      det_neg = det_ff[SUM_W-1];
      bg_sum  = (SUM_W+1)'(nb5_ff) + (SUM_W+1)'(ng5_ff);
      nt_abs  = nt5_ff[SUM_W-1] ? -nt5_ff : nt5_ff;
      hit_in  = !degen5_ff && (nb5_ff > 0) && (ng5_ff > 0) &&
                (bg_sum < signed'({1'b0, den_ff}));
   end

   assign out_valid = vld_ff[5];
   assign out_data  = out_ff;

endmodule

// ===== rtl/core/rti_div.sv =====
// Pipelined restoring divider (one quotient bit per stage) for the hit distance,
// then saturation, the nearest-distance select and the result register. Depends on rti_pkg.

module rti_div
   import rti_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  div_in_type               in_data,
   output logic                     out_valid,
   output logic                     out_hit,
   output logic                     out_degen,
   output logic signed [DIST_W-1:0] out_t
);

   logic [QUO_W:0]     vld_ff;
   div_in_type         op_ff  [QUO_W+1];
   logic [REM_W-1:0]   rem_ff [QUO_W+1];
   logic [QUO_W-1:0]   quo_ff [QUO_W+1];
   logic [REM_W-1:0]   rem_in [QUO_W];
   logic [QUO_W-1:0]   quo_in [QUO_W];

   logic               res_valid_ff;
   logic               res_hit_ff;
   logic               res_degen_ff;
   logic [DIST_W-1:0]  res_t_ff;

   logic [DIST_W-1:0]  q_sat;
   logic signed [DIST_W-1:0] t_val;
   logic signed [DIST_W-1:0] t_in;
   div_in_type         last;

   always_comb begin
      for (int i = 0; i < QUO_W; i++) begin
         logic [SUM_W+FRAC_BITS-1:0] dividend;
         logic [REM_W-1:0]           shifted;
         logic [REM_W-1:0]           den_ext;
         dividend = {op_ff[i].mag, {FRAC_BITS{1'b0}}};
         den_ext  = REM_W'(op_ff[i].den);
         shifted  = {rem_ff[i][REM_W-2:0], dividend[QUO_W-1-i]};
         if (shifted >= den_ext) begin
            rem_in[i] = shifted - den_ext;
            quo_in[i] = {quo_ff[i][QUO_W-2:0], 1'b1};
         end else begin
            rem_in[i] = shifted;
            quo_in[i] = {quo_ff[i][QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[QUO_W-1:0], in_valid};
         res_valid_ff <= vld_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_ff[0]  <= in_data;
         rem_ff[0] <= REM_W'(in_data.mag >> INT_SHIFT);
         quo_ff[0] <= '0;
         for (int i = 0; i < QUO_W; i++) begin
            op_ff[i+1]  <= op_ff[i];
            rem_ff[i+1] <= rem_in[i];
            quo_ff[i+1] <= quo_in[i];
         end
         res_hit_ff   <= last.hit;
         res_degen_ff <= last.degen;
         res_t_ff     <= t_in;
      end
   end

   // Distance magnitude clamp, sign, then the nearer of the hit and the best so far.
   always_comb begin
      last = op_ff[QUO_W];
      if (last.sat) begin
         q_sat = last.neg ? DIST_MIN : DIST_MAX;
      end else if (!last.neg && quo_ff[QUO_W][DIST_W-1]) begin
         q_sat = DIST_MAX;
      end else if (last.neg && (quo_ff[QUO_W] > DIST_MIN)) begin
         q_sat = DIST_MIN;
      end else begin
         q_sat = quo_ff[QUO_W];
      end
      t_val = last.neg ? signed'(-q_sat) : signed'(q_sat);
      if (last.hit && (t_val < last.best)) begin
         t_in = t_val;
      end else begin
         t_in = last.best;
      end
   end

   assign out_valid = res_valid_ff;
   assign out_hit   = res_hit_ff;
   assign out_degen = res_degen_ff;
   assign out_t     = res_t_ff;

endmodule

// ===== rtl/core/ray_triangle_intersect.sv =====
// Ray / triangle intersection by Cramer's rule: top level joining the front end,
// the ray queue, the determinant pipeline and the divider. Depends on rti_pkg.
//
// Usage:
//   Request beats carry tuser = {vertex_select, kind}. A load beat (kind 0) writes
//   vertex a, b or c from the pos fields; a select of 3 is dropped. A ray beat
//   (kind 1) is tested against the stored triangle and gives exactly one response
//   beat, in order. Loads take effect for every ray accepted after them.
//   Response beats carry tuser = {degenerate, hit} and tdata = nearest distance.
//   Throughput is one beat per cycle in both directions while the response side
//   is not stalled. From acceptance a ray passes through the queue, six multiply
//   and sum stages, the divider input register, 32 divider stages (one quotient
//   bit each) and the result register.
//   A stall on the response side freezes the arithmetic pipeline in place; the
//   four-entry queue keeps taking beats until it fills, then req_tready drops.
//   Reset clears the triangle to all zero coordinates and empties the pipeline.

module ray_triangle_intersect
   import rti_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, best_t
   input  logic [127:0] req_tdata,
   // kind, vertex_select
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // nearest_t
   output logic [31:0]  rsp_tdata,
   // hit, degenerate
   output logic [1:0]   rsp_tuser
);

   queue_stat_type q_stat;
   logic           push;
   ray_type        push_data;
   logic           pop;
   ray_type        pop_data;
   logic           en;
   logic           back_valid;
   div_in_type     back_data;
   logic           res_hit;
   logic           res_degen;
   logic signed [DIST_W-1:0] res_t;

   assign en  = !rsp_tvalid || rsp_tready;
   assign pop = en && !q_stat.empty;

   rti_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .push       (push),
      .push_data  (push_data)
   );

   rti_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   rti_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pop),
      .in_ray    (pop_data),
      .out_valid (back_valid),
      .out_data  (back_data)
   );

   rti_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (back_valid),
      .in_data   (back_data),
      .out_valid (rsp_tvalid),
      .out_hit   (res_hit),
      .out_degen (res_degen),
      .out_t     (res_t)
   );

   assign rsp_tdata = res_t;
   assign rsp_tuser = {res_degen, res_hit};

`ifndef NO_ASSERTIONS
   a_no_hit_when_degenerate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("hit reported with a zero determinant");

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("ray queue count beyond its depth");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (q_stat.count != '0))
      else $error("ray queue popped while empty");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");
`endif

endmodule
